[hdl/sync_len_crc_frame_receiver_top_macros.svh]
// Assertion macros used by the frame receiver top level.
`ifndef SYNC_LEN_CRC_FRAME_RECEIVER_TOP_MACROS_SVH
`define SYNC_LEN_CRC_FRAME_RECEIVER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define SLCFR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slcfr check failed");

// Next-cycle implication, disabled during reset.
`define SLCFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slcfr check failed");

`else

`define SLCFR_ASSERT_SAME(label, clk, rst, ante, cons)
`define SLCFR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hdl/slcfr_pkg.sv]
// Shared types and constants of the frame receiver.
package slcfr_pkg;

  // Default payload store depth
  localparam int PAYLOAD_MAX_DEF = 32;

  // Field widths
  localparam int LEN_W  = 6;
  localparam int CNT_W  = 32;
  localparam int EV_W   = 3;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 5;

  // Depth of the command queue between front and back
  localparam int QDEPTH = 2;

  // CRC16-CCITT
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Result event codes
  localparam logic [EV_W-1:0] EV_TAKEN = 3'd0;
  localparam logic [EV_W-1:0] EV_GOOD  = 3'd1;
  localparam logic [EV_W-1:0] EV_SYNC  = 3'd2;
  localparam logic [EV_W-1:0] EV_LEN   = 3'd3;
  localparam logic [EV_W-1:0] EV_CRC   = 3'd4;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH  = 2'd2;

  // Command from front to back: one event, and the length for a good frame
  typedef struct packed {
    logic [EV_W-1:0]  ev;
    logic [LEN_W-1:0] len;
  } q_entry_t;

  // Back status seen by the front
  typedef struct packed {
    logic frame_done;
    logic reading;
  } back_stat_t;

endpackage

[hdl/sync_len_crc_frame_receiver_top.sv]
// Top level of the sync/length/CRC16 frame receiver.
// A byte's result goes via the command queue to the result register when the output is free.
// A good run is read via B_READ and B_WAIT at 1 result per cycle while the output is free.
// Throughput: 1 byte per cycle; payload bytes of the next frame stall while a run is read out
// of the payload store, and the 2-entry command queue fills when the result side stalls.
// Reset (synchronous): clears state and counters, registers to AA, 55, 32; no clearing pass.
`include "sync_len_crc_frame_receiver_top_macros.svh"

module sync_len_crc_frame_receiver_top #(
  parameter int PAYLOAD_MAX = slcfr_pkg::PAYLOAD_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [slcfr_pkg::BYTE_W-1:0]     rx_byte,
  input  logic                             pop,
  output logic                             empty,
  output logic [slcfr_pkg::EV_W-1:0]       event_res,
  output logic [slcfr_pkg::BYTE_W-1:0]     payload_byte,
  output logic [slcfr_pkg::IDX_W-1:0]      byte_index,
  output logic                             last_of_run,
  output logic [slcfr_pkg::CNT_W-1:0]      frame_count,
  output logic [slcfr_pkg::CNT_W-1:0]      crc_error_count,
  output logic [slcfr_pkg::CNT_W-1:0]      sync_error_count,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [3:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

  logic [7:0]                      sync_first, sync_second;
  logic [slcfr_pkg::LEN_W-1:0]     max_length;
  logic                            cfg_wr;

  logic                            q_full, q_empty, q_wr, q_rd;
  slcfr_pkg::q_entry_t             q_wdata, q_rdata;
  slcfr_pkg::back_stat_t           back_stat;
  logic                            ram_we, ram_re;
  logic [AW-1:0]                   ram_waddr, ram_raddr;
  logic [slcfr_pkg::BYTE_W-1:0]    ram_wdata, ram_rdata;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= 8'hAA;
      sync_second <= 8'h55;
      max_length  <= 6'd32;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        slcfr_pkg::REG_SYNC_FIRST:  sync_first  <= pwdata[7:0];
        slcfr_pkg::REG_SYNC_SECOND: sync_second <= pwdata[7:0];
        slcfr_pkg::REG_MAX_LENGTH:  max_length  <= pwdata[slcfr_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[3:2])
      slcfr_pkg::REG_SYNC_FIRST:  prdata = {24'd0, sync_first};
      slcfr_pkg::REG_SYNC_SECOND: prdata = {24'd0, sync_second};
      slcfr_pkg::REG_MAX_LENGTH:  prdata = {26'd0, max_length};
      default:                    prdata = 32'd0;
    endcase
  end

  slcfr_front #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .rx_byte     (rx_byte),
    .sync_first  (sync_first),
    .sync_second (sync_second),
    .max_length  (max_length),
    .q_full      (q_full),
    .q_wr        (q_wr),
    .q_data      (q_wdata),
    .back_stat   (back_stat),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata)
  );

  slcfr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  slcfr_ram #(.WIDTH(slcfr_pkg::BYTE_W), .DEPTH(PAYLOAD_MAX)) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  slcfr_back #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_data           (q_rdata),
    .q_rd             (q_rd),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .back_stat        (back_stat),
    .pop              (pop),
    .empty            (empty),
    .event_res        (event_res),
    .payload_byte     (payload_byte),
    .byte_index       (byte_index),
    .last_of_run      (last_of_run),
    .frame_count      (frame_count),
    .crc_error_count  (crc_error_count),
    .sync_error_count (sync_error_count)
  );

  // Checks
  // payload store is never written while a run is being read out
  `SLCFR_ASSERT_SAME(a_no_write_during_run, clk, rst, ram_we, !back_stat.reading)
  // every non-payload result closes its run
  `SLCFR_ASSERT_SAME(a_single_is_last, clk, rst, !empty && (event_res != slcfr_pkg::EV_GOOD), last_of_run)
  // an accepted beat always lands in the command queue
  `SLCFR_ASSERT_NEXT(a_beat_queued, clk, rst, push && !full, !q_empty)

endmodule

[hdl/slcfr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module slcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/slcfr_front.sv]
// Front end: sync hunt, length check, payload store writes and running CRC.
module slcfr_front #(
  parameter int PAYLOAD_MAX = slcfr_pkg::PAYLOAD_MAX_DEF,
  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [slcfr_pkg::BYTE_W-1:0]     rx_byte,
  input  logic [7:0]                       sync_first,
  input  logic [7:0]                       sync_second,
  input  logic [slcfr_pkg::LEN_W-1:0]      max_length,
  input  logic                             q_full,
  output logic                             q_wr,
  output slcfr_pkg::q_entry_t              q_data,
  input  slcfr_pkg::back_stat_t            back_stat,
  output logic                             ram_we,
  output logic [AW-1:0]                    ram_waddr,
  output logic [slcfr_pkg::BYTE_W-1:0]     ram_wdata
);

  typedef enum logic [5:0] {
    PH_SYNC1   = 6'b000001,
    PH_SYNC2   = 6'b000010,
    PH_LEN     = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CRC_HI  = 6'b010000,
    PH_CRC_LO  = 6'b100000
  } phase_t;

  localparam logic [6:0] PMAX = 7'(PAYLOAD_MAX);

  // One byte through the CRC16-CCITT shift, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ slcfr_pkg::CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  phase_t                          phase, phase_next;
  logic [slcfr_pkg::LEN_W-1:0]     frame_length;
  logic [slcfr_pkg::LEN_W-1:0]     fill_index;
  logic [slcfr_pkg::LEN_W-1:0]     fill_inc;
  logic [15:0]                     crc;
  logic [7:0]                      crc_hi;
  logic                            busy;
  logic                            accept;
  logic [6:0]                      limit;
  logic                            len_ok;
  logic                            crc_match;
  logic [slcfr_pkg::EV_W-1:0]      ev;

  // Payload bytes wait while the back still reads the previous frame
  assign full   = q_full || ((phase == PH_PAYLOAD) && busy);
  assign accept = push && !full;

  assign limit     = ({1'b0, max_length} > PMAX) ? PMAX : {1'b0, max_length};
  assign len_ok    = (rx_byte != 8'd0) && (rx_byte <= {1'b0, limit});
  assign crc_match = (crc == {crc_hi, rx_byte});
  assign fill_inc  = fill_index + 6'd1;

  // Classify the byte
  always_comb begin
    phase_next = PH_SYNC1;
    ev         = slcfr_pkg::EV_TAKEN;
    case (phase)
      PH_SYNC2: begin
        if (rx_byte == sync_second) begin
          phase_next = PH_LEN;
        end else begin
          ev         = slcfr_pkg::EV_SYNC;
          phase_next = (rx_byte == sync_first) ? PH_SYNC2 : PH_SYNC1;
        end
      end
      PH_LEN: begin
        if (len_ok) begin
          phase_next = PH_PAYLOAD;
        end else begin
          ev = slcfr_pkg::EV_LEN;
        end
      end
      PH_PAYLOAD: begin
        phase_next = (fill_inc >= frame_length) ? PH_CRC_HI : PH_PAYLOAD;
      end
      PH_CRC_HI: begin
        phase_next = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        ev = crc_match ? slcfr_pkg::EV_GOOD : slcfr_pkg::EV_CRC;
      end
      default: begin
        if (rx_byte == sync_first) begin
          phase_next = PH_SYNC2;
        end else begin
          ev = slcfr_pkg::EV_SYNC;
        end
      end
    endcase
  end

  // One command per accepted beat
  assign q_wr        = accept;
  assign q_data.ev   = ev;
  assign q_data.len  = frame_length;

  // Payload store write
  assign ram_we    = accept && (phase == PH_PAYLOAD);
  assign ram_waddr = fill_index[AW-1:0];
  assign ram_wdata = rx_byte;

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC1;
      busy         <= 1'b0;
      frame_length <= '0;
      fill_index   <= '0;
      crc          <= slcfr_pkg::CRC_INIT;
    end else begin
      if (back_stat.frame_done) begin
        busy <= 1'b0;
      end
      if (accept) begin
        phase <= phase_next;
        case (phase)
          PH_LEN: begin
            frame_length <= rx_byte[slcfr_pkg::LEN_W-1:0];
            fill_index   <= '0;
            crc          <= crc_feed(slcfr_pkg::CRC_INIT, rx_byte);
          end
          PH_PAYLOAD: begin
            fill_index <= fill_inc;
            crc        <= crc_feed(crc, rx_byte);
          end
          PH_CRC_LO: begin
            if (crc_match) begin
              busy <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // High check byte
  always_ff @(posedge clk) begin
    if (accept && (phase == PH_CRC_HI)) begin
      crc_hi <= rx_byte;
    end
  end

endmodule

[hdl/slcfr_queue.sv]
// Short command queue between front and back.
module slcfr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  slcfr_pkg::q_entry_t wr_data,
  output logic                full,
  input  logic                rd_en,
  output slcfr_pkg::q_entry_t rd_data,
  output logic                empty
);

  localparam int PW = (slcfr_pkg::QDEPTH > 1) ? $clog2(slcfr_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(slcfr_pkg::QDEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(slcfr_pkg::QDEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(slcfr_pkg::QDEPTH);

  slcfr_pkg::q_entry_t slots [slcfr_pkg::QDEPTH];
  logic [PW-1:0]       wr_ptr, rd_ptr;
  logic [CW-1:0]       count;
  logic                do_wr, do_rd;

  assign full    = (count == DEPTH_C);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

[hdl/slcfr_back.sv]
// Back end: counters, payload run readout and the result register.
module slcfr_back #(
  parameter int PAYLOAD_MAX = slcfr_pkg::PAYLOAD_MAX_DEF,
  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  input  slcfr_pkg::q_entry_t              q_data,
  output logic                             q_rd,
  output logic                             ram_re,
  output logic [AW-1:0]                    ram_raddr,
  input  logic [slcfr_pkg::BYTE_W-1:0]     ram_rdata,
  output slcfr_pkg::back_stat_t            back_stat,
  input  logic                             pop,
  output logic                             empty,
  output logic [slcfr_pkg::EV_W-1:0]       event_res,
  output logic [slcfr_pkg::BYTE_W-1:0]     payload_byte,
  output logic [slcfr_pkg::IDX_W-1:0]      byte_index,
  output logic                             last_of_run,
  output logic [slcfr_pkg::CNT_W-1:0]      frame_count,
  output logic [slcfr_pkg::CNT_W-1:0]      crc_error_count,
  output logic [slcfr_pkg::CNT_W-1:0]      sync_error_count
);

  localparam int CNT_W = slcfr_pkg::CNT_W;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_WAIT = 3'b100
  } bstate_t;

  bstate_t                          state;
  logic [slcfr_pkg::LEN_W-1:0]      idx, idx_inc, run_len;
  logic                             last;
  logic                             out_valid, out_free;
  logic                             load_single, load_pay;
  logic [slcfr_pkg::CNT_W-1:0]      good_cnt, good_cnt_next;
  logic [slcfr_pkg::CNT_W-1:0]      crc_cnt, crc_cnt_next;
  logic [slcfr_pkg::CNT_W-1:0]      sync_cnt, sync_cnt_next;
  logic                             take;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign idx_inc  = idx + 6'd1;
  assign last     = (idx_inc == run_len);

  // Pop control and payload reads
  always_comb begin
    q_rd        = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = idx[AW-1:0];
    load_single = 1'b0;
    load_pay    = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_data.ev == slcfr_pkg::EV_GOOD) begin
            q_rd = 1'b1;
          end else if (out_free) begin
            q_rd        = 1'b1;
            load_single = 1'b1;
          end
        end
      end
      B_READ: begin
        ram_re = 1'b1;
      end
      B_WAIT: begin
        if (out_free) begin
          load_pay = 1'b1;
          if (!last) begin
            ram_re    = 1'b1;
            ram_raddr = idx_inc[AW-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Counter updates for the popped command
  assign take          = q_rd;
  assign good_cnt_next = good_cnt + CNT_W'(take && (q_data.ev == slcfr_pkg::EV_GOOD));
  assign crc_cnt_next  = crc_cnt + CNT_W'(take && (q_data.ev == slcfr_pkg::EV_CRC));
  assign sync_cnt_next = sync_cnt + CNT_W'(take && ((q_data.ev == slcfr_pkg::EV_SYNC) ||
                                                   (q_data.ev == slcfr_pkg::EV_LEN)));

  assign back_stat.reading    = (state != B_IDLE);
  assign back_stat.frame_done = load_pay && last;

  // Sequencer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      good_cnt  <= '0;
      crc_cnt   <= '0;
      sync_cnt  <= '0;
      idx       <= '0;
      run_len   <= '0;
    end else begin
      good_cnt <= good_cnt_next;
      crc_cnt  <= crc_cnt_next;
      sync_cnt <= sync_cnt_next;
      if (load_single || load_pay) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_rd && (q_data.ev == slcfr_pkg::EV_GOOD)) begin
            state   <= B_READ;
            idx     <= '0;
            run_len <= q_data.len;
          end
        end
        B_READ: begin
          state <= B_WAIT;
        end
        B_WAIT: begin
          if (load_pay) begin
            if (last) begin
              state <= B_IDLE;
            end else begin
              idx <= idx_inc;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load_single) begin
      event_res    <= q_data.ev;
      payload_byte <= '0;
      byte_index   <= '0;
      last_of_run  <= 1'b1;
    end else if (load_pay) begin
      event_res    <= slcfr_pkg::EV_GOOD;
      payload_byte <= ram_rdata;
      byte_index   <= idx[slcfr_pkg::IDX_W-1:0];
      last_of_run  <= last;
    end
    if (load_single || load_pay) begin
      frame_count      <= good_cnt_next;
      crc_error_count  <= crc_cnt_next;
      sync_error_count <= sync_cnt_next;
    end
  end

endmodule
